FILE: rtl/pdu_pkg.sv
package pdu_pkg;

  // upwind choice taken from the sign of the Roe normal velocity
  typedef enum logic [1:0] {
    W_RIGHT = 2'd0,
    W_HALF  = 2'd1,
    W_LEFT  = 2'd2
  } wsel_t;

  localparam int unsigned DataW = 32;
  localparam int unsigned ProdW = 2 * DataW;
  // doubled Q32.32 value with room for the half-case sum
  localparam int unsigned UpwW     = ProdW + 2;
  localparam int unsigned UpwShift = 17;

endpackage

FILE: rtl/pressureless_dust_upwind_flux.sv
// Pressureless dust interface flux, Q16.16 in and out. One interface is taken every
// cycle while in_ready is high. The eight register stages are: input select,
// squares and mass products, partial products of rho*vn^2, their 96-bit sums,
// the Roe sign compare, the upwinded mass flux, the six momentum products, and the
// upwinded momentum fluxes. Each stage holds only while the one after it is full and
// stalled, so bubbles close up and in_ready drops only when all eight stages hold an
// item and out_ready is low. sweep_dir = 3 is taken as x.
module pressureless_dust_upwind_flux (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         sweep_dir,
  input  logic [31:0]        rho_left,
  input  logic signed [31:0] vx_left,
  input  logic signed [31:0] vy_left,
  input  logic signed [31:0] vz_left,
  input  logic [31:0]        rho_right,
  input  logic signed [31:0] vx_right,
  input  logic signed [31:0] vy_right,
  input  logic signed [31:0] vz_right,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] mass_flux,
  output logic signed [31:0] mom_x_flux,
  output logic signed [31:0] mom_y_flux,
  output logic signed [31:0] mom_z_flux
);

  typedef enum logic [1:0] {
    DIR_X = 2'd0,
    DIR_Y = 2'd1,
    DIR_Z = 2'd2
  } dir_t;

  typedef struct packed {
    logic signed [31:0] xl;
    logic signed [31:0] yl;
    logic signed [31:0] zl;
    logic signed [31:0] xr;
    logic signed [31:0] yr;
    logic signed [31:0] zr;
  } vel_t;

  typedef struct packed {
    logic lp;
    logic ln;
    logic rp;
    logic rn;
    logic blk;
  } sflag_t;

  function automatic pdu_pkg::wsel_t sgn_w(input logic pos, input logic neg);
    if (pos) begin
      return pdu_pkg::W_LEFT;
    end else if (neg) begin
      return pdu_pkg::W_RIGHT;
    end else begin
      return pdu_pkg::W_HALF;
    end
  endfunction

  logic [8:1] v;
  logic [8:1] rdy;

  // stage 1
  vel_t               vel_d, vel1, vel2, vel3, vel4, vel5, vel6;
  logic signed [31:0] vln_d, vrn_d, vln1, vrn1;
  logic [31:0]        aln_d, arn_d, aln1, arn1;
  logic [31:0]        rl1, rr1, rl2, rr2;
  sflag_t             fl_d, fl1, fl2, fl3, fl4, fl5;
  // stage 2
  logic [63:0]        ml2, mr2;
  logic signed [64:0] pl_d, pr_d;
  logic signed [63:0] pl2, pr2, pl3, pr3, pl4, pr4, pl5, pr5;
  // stage 3, 4
  logic [63:0]        llo3, lhi3, rlo3, rhi3;
  logic [95:0]        lmag4, rmag4;
  // stage 5
  pdu_pkg::wsel_t     w_d, w5, w6, w7;
  // stage 6, 7
  logic signed [31:0] mass_d, mass6, mass7;
  logic signed [63:0] pxl7, pyl7, pzl7, pxr7, pyr7, pzr7;
  logic signed [31:0] mx_d, my_d, mz_d;

  // bubbles collapse: a stage loads when empty or when the next one loads
  always_comb begin
    rdy[8] = !v[8] || out_ready;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= in_valid;
      end
      for (int k = 2; k <= 8; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: pick the normal direction, magnitudes and sign flags
  always_comb begin
    case (dir_t'(sweep_dir))
      DIR_Y: begin
        vln_d = vy_left;
        vrn_d = vy_right;
      end
      DIR_Z: begin
        vln_d = vz_left;
        vrn_d = vz_right;
      end
      default: begin
        vln_d = vx_left;
        vrn_d = vx_right;
      end
    endcase
    aln_d = vln_d[31] ? (~vln_d + 32'sd1) : vln_d;
    arn_d = vrn_d[31] ? (~vrn_d + 32'sd1) : vrn_d;
    // zero density means zero weight in the Roe sum
    fl_d.lp  = (rho_left != '0) && !vln_d[31] && (vln_d != '0);
    fl_d.ln  = (rho_left != '0) && vln_d[31];
    fl_d.rp  = (rho_right != '0) && !vrn_d[31] && (vrn_d != '0);
    fl_d.rn  = (rho_right != '0) && vrn_d[31];
    fl_d.blk = vln_d[31] && !vrn_d[31] && (vrn_d != '0);
    vel_d = '{xl: vx_left, yl: vy_left, zl: vz_left,
              xr: vx_right, yr: vy_right, zr: vz_right};
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      vel1 <= vel_d;
      vln1 <= vln_d;
      vrn1 <= vrn_d;
      aln1 <= aln_d;
      arn1 <= arn_d;
      rl1  <= rho_left;
      rr1  <= rho_right;
      fl1  <= fl_d;
    end
  end

  // stage 2: vn^2 and rho*vn
  assign pl_d = $signed({1'b0, rl1}) * vln1;
  assign pr_d = $signed({1'b0, rr1}) * vrn1;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      ml2  <= aln1 * aln1;
      mr2  <= arn1 * arn1;
      pl2  <= pl_d[63:0];
      pr2  <= pr_d[63:0];
      rl2  <= rl1;
      rr2  <= rr1;
      fl2  <= fl1;
      vel2 <= vel1;
    end
  end

  // stage 3: rho * vn^2 as two 32x32 partial products per side
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      llo3 <= rl2 * ml2[31:0];
      lhi3 <= rl2 * ml2[63:32];
      rlo3 <= rr2 * mr2[31:0];
      rhi3 <= rr2 * mr2[63:32];
      pl3  <= pl2;
      pr3  <= pr2;
      fl3  <= fl2;
      vel3 <= vel2;
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      lmag4 <= {32'd0, llo3} + {lhi3, 32'd0};
      rmag4 <= {32'd0, rlo3} + {rhi3, 32'd0};
      pl4   <= pl3;
      pr4   <= pr3;
      fl4   <= fl3;
      vel4  <= vel3;
    end
  end

  // stage 5: Roe sign; only opposite nonzero signs need the magnitude compare
  always_comb begin
    if (!fl4.lp && !fl4.ln) begin
      w_d = sgn_w(fl4.rp, fl4.rn);
    end else if ((!fl4.rp && !fl4.rn) || (fl4.lp && fl4.rp) || (fl4.ln && fl4.rn)) begin
      w_d = sgn_w(fl4.lp, fl4.ln);
    end else if (lmag4 > rmag4) begin
      w_d = sgn_w(fl4.lp, fl4.ln);
    end else if (lmag4 < rmag4) begin
      w_d = sgn_w(fl4.rp, fl4.rn);
    end else begin
      w_d = pdu_pkg::W_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      w5   <= w_d;
      pl5  <= pl4;
      pr5  <= pr4;
      fl5  <= fl4;
      vel5 <= vel4;
    end
  end

  // stage 6: mass flux; a diverging pair zeroes it and so every momentum flux
  pdu_upwind u_mass (
    .w  (w5),
    .pl (pl5),
    .pr (pr5),
    .q  (mass_d)
  );

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      mass6 <= fl5.blk ? '0 : mass_d;
      w6    <= w5;
      vel6  <= vel5;
    end
  end

  // stage 7: velocity times saturated mass flux
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      pxl7  <= vel6.xl * mass6;
      pyl7  <= vel6.yl * mass6;
      pzl7  <= vel6.zl * mass6;
      pxr7  <= vel6.xr * mass6;
      pyr7  <= vel6.yr * mass6;
      pzr7  <= vel6.zr * mass6;
      mass7 <= mass6;
      w7    <= w6;
    end
  end

  // stage 8
  pdu_upwind u_mom_x (
    .w  (w7),
    .pl (pxl7),
    .pr (pxr7),
    .q  (mx_d)
  );

  pdu_upwind u_mom_y (
    .w  (w7),
    .pl (pyl7),
    .pr (pyr7),
    .q  (my_d)
  );

  pdu_upwind u_mom_z (
    .w  (w7),
    .pl (pzl7),
    .pr (pzr7),
    .q  (mz_d)
  );

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      mass_flux  <= mass7;
      mom_x_flux <= mx_d;
      mom_y_flux <= my_d;
      mom_z_flux <= mz_d;
    end
  end

  a_blk_zero: assert property (@(posedge clk) disable iff (rst)
    v[5] && rdy[6] && fl5.blk |=> mass6 == '0)
    else $error("diverging interface gave nonzero mass flux");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v) && !out_ready)
    else $error("input stalled with a bubble in the pipe");

  a_hold_mass: assert property (@(posedge clk) disable iff (rst)
    v[6] && !rdy[7] |=> $stable(mass6) && v[6])
    else $error("stalled mass stage changed");

endmodule

FILE: rtl/pdu_upwind.sv
// Upwinds a pair of Q32.32 products, floors to Q16.16 and saturates.
// The half case is floor((pl + pr) / 2), built from the doubled value.
module pdu_upwind (
  input  pdu_pkg::wsel_t                     w,
  input  logic signed [pdu_pkg::ProdW-1:0]   pl,
  input  logic signed [pdu_pkg::ProdW-1:0]   pr,
  output logic signed [pdu_pkg::DataW-1:0]   q
);

  logic signed [pdu_pkg::UpwW-1:0] v2;
  logic        [pdu_pkg::UpwW-1:0] sh;
  logic                            in_range;

  always_comb begin
    case (w)
      pdu_pkg::W_LEFT: begin
        v2 = {pl[pdu_pkg::ProdW-1], pl, 1'b0};
      end
      pdu_pkg::W_RIGHT: begin
        v2 = {pr[pdu_pkg::ProdW-1], pr, 1'b0};
      end
      default: begin
        v2 = {{2{pl[pdu_pkg::ProdW-1]}}, pl} + {{2{pr[pdu_pkg::ProdW-1]}}, pr};
      end
    endcase
    sh = {{pdu_pkg::UpwShift{v2[pdu_pkg::UpwW-1]}},
          v2[pdu_pkg::UpwW-1:pdu_pkg::UpwShift]};
    in_range = (&sh[pdu_pkg::UpwW-1:pdu_pkg::DataW-1]) ||
               !(|sh[pdu_pkg::UpwW-1:pdu_pkg::DataW-1]);
    if (in_range) begin
      q = sh[pdu_pkg::DataW-1:0];
    end else if (sh[pdu_pkg::UpwW-1]) begin
      q = {1'b1, {(pdu_pkg::DataW-1){1'b0}}};
    end else begin
      q = {1'b0, {(pdu_pkg::DataW-1){1'b1}}};
    end
  end

endmodule
